FILE: rtl/core/bhk_pkg.sv
// ----------------------------------------------------------------------------
// bhk_pkg
// Shared types and constants for the button to HID key report unit.
// ----------------------------------------------------------------------------
package bhk_pkg;

  localparam int NUM_MAP_REGS = 4;   // buttons that own a mapping register
  localparam int OUT_SLOTS    = 6;   // key slots carried in a report
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAP0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd5;

  localparam logic [15:0] MAP0_RST = 16'd44;
  localparam logic [15:0] MAP1_RST = 16'd40;
  localparam logic [15:0] MAP2_RST = 16'd30;
  localparam logic [15:0] MAP3_RST = 16'd31;
  localparam logic [NUM_MAP_REGS-1:0] ENABLE_RST = 4'hF;

  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 20'd180000;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_MIN = 20'd30000;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_MAX = 20'd600000;

  // one slot operation from the sequencer to the slot store
  typedef struct packed {
    logic       valid;
    logic       add;    // 1: add keycode, 0: remove keycode
    logic [7:0] code;
  } slot_op_t;

endpackage

FILE: rtl/core/bhk_cfg.sv
// ----------------------------------------------------------------------------
// bhk_cfg
// Configuration registers: button mappings, enable mask and sleep timeout.
// ----------------------------------------------------------------------------
module bhk_cfg
  import bhk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [CFG_IDX_W-1:0]    wr_index,
  input  logic [CFG_DATA_W-1:0]   wr_data,
  output logic [15:0]             mapping [NUM_MAP_REGS],
  output logic [NUM_MAP_REGS-1:0] enable_mask,
  output logic [CFG_DATA_W-1:0]   timeout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping[0]  <= MAP0_RST;
      mapping[1]  <= MAP1_RST;
      mapping[2]  <= MAP2_RST;
      mapping[3]  <= MAP3_RST;
      enable_mask <= ENABLE_RST;
      timeout     <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MAP0:   mapping[0]  <= wr_data[15:0];
        CFG_MAP1:   mapping[1]  <= wr_data[15:0];
        CFG_MAP2:   mapping[2]  <= wr_data[15:0];
        CFG_MAP3:   mapping[3]  <= wr_data[15:0];
        CFG_ENABLE: enable_mask <= wr_data[NUM_MAP_REGS-1:0];
        CFG_TIMEOUT: begin
          // out of range values are dropped
          if (wr_data >= TIMEOUT_MIN && wr_data <= TIMEOUT_MAX) timeout <= wr_data;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/bhk_slots.sv
// ----------------------------------------------------------------------------
// bhk_slots
// Key slot store with a shared add / remove compare unit, one op per cycle.
// ----------------------------------------------------------------------------
module bhk_slots
  import bhk_pkg::*;
#(
  parameter int SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  slot_op_t   op,
  output logic [7:0] slot [SLOTS]
);

  logic [SLOTS-1:0] match;
  logic [SLOTS-1:0] empty;
  logic [SLOTS-1:0] first_empty;
  logic             seen;

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i]       = (slot[i] == op.code);
      empty[i]       = (slot[i] == 8'd0);
      first_empty[i] = empty[i] && !seen;
      seen           = seen || empty[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot[i] <= 8'd0;
    end else if (op.valid) begin
      if (op.add) begin
        // keycode 0 and duplicates are not added; full store drops it
        if (op.code != 8'd0 && match == '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (first_empty[i]) slot[i] <= op.code;
          end
        end
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (match[i]) slot[i] <= 8'd0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/button_to_hid_key_report_unit.sv
// ----------------------------------------------------------------------------
// button_to_hid_key_report_unit
// Turns button polls into 6-key rollover keyboard reports and sleep requests.
// ----------------------------------------------------------------------------
// Each poll beat carries the button levels and a wrapping millisecond time.
// Enabled buttons whose level differs from their held bit are handled in
// index order: a press adds the keycode to the first free slot (not for
// keycode 0, a duplicate, or a full store), a release empties every slot
// with that keycode. Each change gives one report beat (modifier OR of held
// buttons plus six slots). A poll with no change checks the wrapping time
// since last activity and, past the timeout, gives one sleep beat with an
// all-zero report. last_of_run marks the final beat of a poll; a poll with
// nothing to say gives no beat. Rate: one poll at a time; the sequencer
// visits one button per cycle through the shared slot compare unit, but
// holds on a changed button while its report beat is built and until the
// sink takes it. It stops after the last changed button. Config writes
// are always taken and apply at once.
module button_to_hid_key_report_unit
  import bhk_pkg::*;
#(
  parameter int NUM_KEYS_IN  = 4,
  parameter int REPORT_SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  // poll channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            pressed_mask,
  input  logic [31:0]           now_ms,
  // report channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            modifier_bits,
  output logic [7:0]            key_slot_a,
  output logic [7:0]            key_slot_b,
  output logic [7:0]            key_slot_c,
  output logic [7:0]            key_slot_d,
  output logic [7:0]            key_slot_e,
  output logic [7:0]            key_slot_f,
  output logic                  sleep_request,
  output logic                  last_of_run,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // only buttons with a mapping register can ever be enabled
  localparam int BTN   = (NUM_KEYS_IN < NUM_MAP_REGS) ? NUM_KEYS_IN : NUM_MAP_REGS;
  localparam int IDX_W = (BTN > 1) ? $clog2(BTN) : 1;

  typedef enum logic [2:0] {IDLE, STEP, EMIT, TOCHK, WAIT} state_t;

  state_t                  state;
  logic [IDX_W-1:0]        idx;
  logic [BTN-1:0]          pend;       // buttons still to be handled
  logic [BTN-1:0]          pressed;
  logic [BTN-1:0]          held;
  logic [31:0]             now;
  logic [31:0]             last_activity;

  logic [15:0]             mapping [NUM_MAP_REGS];
  logic [NUM_MAP_REGS-1:0] enable_mask;
  logic [CFG_DATA_W-1:0]   timeout;

  slot_op_t                op;
  logic [7:0]              slot_q   [REPORT_SLOTS];
  logic [7:0]              rep_slot [OUT_SLOTS];
  logic [BTN-1:0]          chg;
  logic [7:0]              mods;
  logic [31:0]             idle_time;
  logic                    asleep;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);

  bhk_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .mapping     (mapping),
    .enable_mask (enable_mask),
    .timeout     (timeout)
  );

  // slot op issued while the sequencer sits on a changed button
  always_comb begin
    op.valid = (state == STEP) && pend[idx];
    op.add   = pressed[idx];
    op.code  = mapping[idx][7:0];
  end

  bhk_slots #(.SLOTS(REPORT_SLOTS)) u_slots (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .slot (slot_q)
  );

  // fewer slots than the report carries read as empty
  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_rep
    if (j < REPORT_SLOTS) begin : g_have
      assign rep_slot[j] = slot_q[j];
    end else begin : g_none
      assign rep_slot[j] = 8'd0;
    end
  end

  // changes are fixed at poll time: each button only touches its own held bit
  assign chg = (pressed_mask[BTN-1:0] ^ held) & enable_mask[BTN-1:0];

  always_comb begin
    mods = 8'd0;
    for (int i = 0; i < BTN; i++) begin
      if (held[i]) mods = mods | mapping[i][15:8];
    end
  end

  // wrapping idle time; any change would have stamped activity to now
  assign idle_time = now - last_activity;
  assign asleep    = idle_time > {12'd0, timeout};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      idx           <= '0;
      pend          <= '0;
      held          <= '0;
      last_activity <= 32'd0;
      out_valid     <= 1'b0;
      last_of_run   <= 1'b0;
      sleep_request <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            pressed <= pressed_mask[BTN-1:0];
            now     <= now_ms;
            pend    <= chg;
            idx     <= '0;
            state   <= (chg != '0) ? STEP : TOCHK;
          end
        end
        STEP: begin
          if (pend[idx]) begin
            pend[idx]     <= 1'b0;
            held[idx]     <= pressed[idx];
            last_activity <= now;
            state         <= EMIT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        EMIT: begin
          // slots and held bits now reflect this change
          out_valid     <= 1'b1;
          modifier_bits <= mods;
          key_slot_a    <= rep_slot[0];
          key_slot_b    <= rep_slot[1];
          key_slot_c    <= rep_slot[2];
          key_slot_d    <= rep_slot[3];
          key_slot_e    <= rep_slot[4];
          key_slot_f    <= rep_slot[5];
          sleep_request <= 1'b0;
          last_of_run   <= (pend == '0);
          state         <= WAIT;
        end
        TOCHK: begin
          if (asleep) begin
            out_valid     <= 1'b1;
            modifier_bits <= 8'd0;
            key_slot_a    <= 8'd0;
            key_slot_b    <= 8'd0;
            key_slot_c    <= 8'd0;
            key_slot_d    <= 8'd0;
            key_slot_e    <= 8'd0;
            key_slot_f    <= 8'd0;
            sleep_request <= 1'b1;
            last_of_run   <= 1'b1;
            state         <= WAIT;
          end else begin
            state <= IDLE;
          end
        end
        WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_of_run) begin
              state <= IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= STEP;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bhk_checker.sv
// ----------------------------------------------------------------------------
// bhk_checker
// Port level checks for the button to HID key report unit.
// ----------------------------------------------------------------------------
module bhk_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] modifier_bits,
  input logic [7:0] key_slot_a,
  input logic [7:0] key_slot_f,
  input logic       sleep_request,
  input logic       last_of_run
);

  // one poll at a time: no new poll while a beat is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("poll taken while a report beat is pending");

  a_busy_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after poll accepted");

  // sleep beat closes the poll; its modifiers and slots a and f are zero
  a_sleep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sleep_request) |->
      (last_of_run && modifier_bits == 8'd0 && key_slot_a == 8'd0 &&
       key_slot_f == 8'd0))
    else $error("sleep beat not last or report not empty");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(key_slot_a) &&
      $stable(last_of_run)))
    else $error("stalled report beat changed");

endmodule

bind button_to_hid_key_report_unit bhk_checker u_bhk_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .modifier_bits (modifier_bits),
  .key_slot_a    (key_slot_a),
  .key_slot_f    (key_slot_f),
  .sleep_request (sleep_request),
  .last_of_run   (last_of_run)
);
